// ===== src/insertion_sorter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// insertion_sorter_unit_assert.svh
// Assertion macros used by the sorter checker.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_UNIT_ASSERT_SVH
`define INSERTION_SORTER_UNIT_ASSERT_SVH

// same-cycle implication
`define INS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define INS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ins_pkg.sv =====
// ----------------------------------------------------------------------------
// ins_pkg
// Constants and link types of the insertion sorter cell chain.
// ----------------------------------------------------------------------------
package ins_pkg;

   localparam int STORE_DEPTH = 16;
   localparam int DATA_W      = 32;

   // what a cell shows its neighbors
   typedef struct packed {
      logic                     occupied;
      logic                     greater;
      logic signed [DATA_W-1:0] key;
   } link_type;

   // broadcast control from the top level
   typedef struct packed {
      logic                     insert_en;
      logic                     drain_en;
      logic signed [DATA_W-1:0] value;
   } ctrl_type;

endpackage

// ===== src/ins_cell.sv =====
// ----------------------------------------------------------------------------
// ins_cell
// One slot of the sorted chain: compares the broadcast value with its key,
// takes the left neighbor's key or the new value on insert, and takes the
// right neighbor's key when the chain drains.
// ----------------------------------------------------------------------------
module ins_cell (
   input  logic              clock,
   input  logic              reset,
   input  ins_pkg::ctrl_type ctrl,
   input  ins_pkg::link_type left_link,
   input  ins_pkg::link_type right_link,
   output ins_pkg::link_type self_link
);

   logic                              occ_ff, occ_in;
   logic signed [ins_pkg::DATA_W-1:0] key_ff, key_in;
   logic                              greater;
   logic                              take;

   assign greater = occ_ff && (key_ff > ctrl.value);
   // occupied cells move up when greater; the first free cell takes the tail
   assign take    = occ_ff ? greater : left_link.occupied;

   always_comb begin
      priority if (ctrl.drain_en) begin
         occ_in = right_link.occupied;
         key_in = right_link.key;
      end else if (ctrl.insert_en && take) begin
         occ_in = 1'b1;
         key_in = left_link.greater ? left_link.key : ctrl.value;
      end else begin
         occ_in = occ_ff;
         key_in = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign self_link.occupied = occ_ff;
   assign self_link.greater  = greater;
   assign self_link.key      = key_ff;

endmodule

// ===== src/insertion_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter_unit
// Stable ascending sort of a batch of signed values in a chain of cells.
//
//   channel  ports                                        direction
//   req      req_valid req_stall req_value req_end_of_batch  in
//   rsp      rsp_valid rsp_stall rsp_sorted_value
//            rsp_final_result rsp_overflowed                 out
//
// Loading takes one beat per cycle: every cell compares and shifts at once.
// After the end-of-batch beat the chain drains from its head, one result per
// cycle while rsp_stall is low. req_stall is high while draining. rsp_stall
// freezes the chain head.
// Synchronous reset empties the chain; key registers are not reset.
// ----------------------------------------------------------------------------
module insertion_sorter_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [ins_pkg::DATA_W-1:0] req_value,
   input  logic                              req_end_of_batch,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ins_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                              rsp_final_result,
   output logic                              rsp_overflowed
);

   ins_pkg::link_type links [ins_pkg::STORE_DEPTH];
   ins_pkg::ctrl_type ctrl;

   logic drain_ff, drain_in;
   logic ovf_ff, ovf_in;
   logic req_beat, rsp_beat, full;

   assign full      = links[ins_pkg::STORE_DEPTH-1].occupied;
   assign req_stall = drain_ff;
   assign req_beat  = req_valid && !drain_ff;
   assign rsp_valid = drain_ff && links[0].occupied;
   assign rsp_beat  = rsp_valid && !rsp_stall;

   assign ctrl.insert_en = req_beat && !full;
   assign ctrl.drain_en  = rsp_beat;
   assign ctrl.value     = req_value;

   assign rsp_sorted_value = links[0].key;
   assign rsp_final_result = !links[1].occupied;
   assign rsp_overflowed   = ovf_ff;

   always_comb begin
      priority if (rsp_beat && rsp_final_result) begin
         drain_in = 1'b0;
         ovf_in   = 1'b0;
      end else if (req_beat) begin
         drain_in = req_end_of_batch;
         ovf_in   = ovf_ff || full;
      end else begin
         drain_in = drain_ff;
         ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         drain_ff <= drain_in;
         ovf_ff   <= ovf_in;
      end
   end

   for (genvar i = 0; i < ins_pkg::STORE_DEPTH; i++) begin : g_cell
      ins_pkg::link_type left_l, right_l;

      if (i == 0) begin : g_head
         assign left_l = '{occupied: 1'b1, greater: 1'b0, key: '0};
      end else begin : g_body
         assign left_l = links[i-1];
      end

      if (i == ins_pkg::STORE_DEPTH - 1) begin : g_tail
         assign right_l = '{occupied: 1'b0, greater: 1'b0, key: '0};
      end else begin : g_inner
         assign right_l = links[i+1];
      end

      ins_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_link  (left_l),
         .right_link (right_l),
         .self_link  (links[i])
      );
   end

endmodule

// ===== src/ins_checker.sv =====
// ----------------------------------------------------------------------------
// ins_checker
// Port-level checks of the insertion sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "insertion_sorter_unit_assert.svh"

module ins_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_end_of_batch,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [ins_pkg::DATA_W-1:0] rsp_sorted_value,
   input logic                              rsp_final_result,
   input logic                              rsp_overflowed
);

   logic req_beat, rsp_beat;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   `INS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sorted_value) && $stable(rsp_overflowed), "stalled rsp beat changed")
   `INS_ASSERT_NOW(a_no_load_in_drain, clock, reset, rsp_valid, req_stall, "req taken while draining")
   `INS_ASSERT_NEXT(a_end_drains, clock, reset, req_beat && req_end_of_batch, rsp_valid, "no result after end of batch")
   `INS_ASSERT_NEXT(a_final_frees, clock, reset, rsp_beat && rsp_final_result, !rsp_valid && !req_stall, "sorter not idle after final beat")

endmodule

bind insertion_sorter_unit ins_checker u_ins_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_end_of_batch (req_end_of_batch),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sorted_value (rsp_sorted_value),
   .rsp_final_result (rsp_final_result),
   .rsp_overflowed   (rsp_overflowed)
);

// ===== dv/insertion_sorter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter_unit_tb
// Self-checking bench for the insertion sorter: directed and random batches.
//
// Batches of signed values go in on the req channel, and each batch ends
// with an end-of-batch beat. A local sort model works out the ordered
// drain of every batch, including the overflow flag once the store is full.
// Every rsp beat is compared against the model.
// Both sides insert random idle cycles. A long receiver hold keeps the
// chain draining and so keeps req_stall high.
// ----------------------------------------------------------------------------
module insertion_sorter_unit_tb;

   localparam int DEPTH = ins_pkg::STORE_DEPTH;
   localparam int W     = ins_pkg::DATA_W;

   typedef logic signed [W-1:0] word_type;

   localparam word_type MIN_VALUE = {1'b1, {(W-1){1'b0}}};
   localparam word_type MAX_VALUE = {1'b0, {(W-1){1'b1}}};

   typedef struct {
      word_type sorted_value;
      logic     final_result;
      logic     overflowed;
   } sorted_beat_type;

   logic     clock            = 1'b0;
   logic     reset            = 1'b1;
   logic     req_valid        = 1'b0;
   logic     req_stall;
   word_type req_value        = '0;
   logic     req_end_of_batch = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall        = 1'b0;
   word_type rsp_sorted_value;
   logic     rsp_final_result;
   logic     rsp_overflowed;

   // sort model state
   word_type        model_keys[DEPTH];
   int unsigned     model_fill = 0;
   bit              model_dropped = 1'b0;
   sorted_beat_type pending_sorted[$];

   int mismatch_count = 0;
   int req_max_gap    = 10;
   int rsp_max_gap    = 10;
   int rsp_stall_left = 0;
   int rsp_hold_left  = 0;
   int hold_request   = 0;
   int random_sent    = 0;

   insertion_sorter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_end_of_batch (req_end_of_batch),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_result (rsp_final_result),
      .rsp_overflowed   (rsp_overflowed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // insert one accepted beat; on end of batch, queue the ordered drain
   task automatic sort_into_model(input word_type v, input logic eob);
      int unsigned pos;
      sorted_beat_type b;
      if (model_fill < DEPTH) begin
         pos = model_fill;
         while (pos > 0 && model_keys[pos-1] > v) begin
            model_keys[pos] = model_keys[pos-1];
            pos--;
         end
         model_keys[pos] = v;
         model_fill++;
      end else begin
         model_dropped = 1'b1;
      end
      if (eob) begin
         for (int i = 0; i < model_fill; i++) begin
            b.sorted_value = model_keys[i];
            b.final_result = (i + 1 == model_fill);
            b.overflowed   = model_dropped;
            pending_sorted.push_back(b);
         end
         model_fill    = 0;
         model_dropped = 1'b0;
      end
   endtask

   // called right after a rising edge; returns at the edge that took the beat
   task automatic send_beat(input word_type v, input logic eob);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_value        <= v;
      req_end_of_batch <= eob;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sort_into_model(v, eob);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_sorted.size() != 0) @(posedge clock);
   endtask

   function automatic word_type draw_value();
      unique case ($urandom_range(0, 9))
         0:       return MIN_VALUE;
         1:       return MAX_VALUE;
         2, 3:    return word_type'(int'($urandom_range(0, 15)) - 8);
         default: return word_type'($urandom);
      endcase
   endfunction

   task automatic send_random_batch(input int len);
      for (int i = 0; i < len; i++) begin
         send_beat(draw_value(), i == len - 1);
         random_sent++;
      end
   endtask

   function automatic int draw_batch_len();
      if ($urandom_range(0, 6) == 0) return $urandom_range(DEPTH + 1, DEPTH + 8);
      return $urandom_range(1, DEPTH);
   endfunction

   task automatic test_extremes();
      send_beat(MAX_VALUE, 1'b0);
      send_beat(MIN_VALUE, 1'b0);
      send_beat(0, 1'b0);
      send_beat(-1, 1'b0);
      send_beat(1, 1'b1);
      send_beat(MIN_VALUE, 1'b1);
   endtask

   task automatic test_duplicates();
      send_beat(7, 1'b0);
      send_beat(-3, 1'b0);
      send_beat(7, 1'b1);
   endtask

   // descending fill forces a full shift on every insert; the end beat is dropped
   task automatic test_overflow();
      for (int i = 0; i < DEPTH; i++)
         send_beat(word_type'(DEPTH - i) * 1000, 1'b0);
      send_beat(MIN_VALUE, 1'b1);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      req_max_gap  = 0;
      rsp_max_gap  = 0;
      hold_request = 150;
      send_random_batch(6);
      send_random_batch(DEPTH + 2);
      req_max_gap = 10;
      rsp_max_gap = 10;
      send_random_batch(8);
      wait_for_results();
   endtask

   task automatic test_random();
      while (random_sent < 130) begin
         req_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
         rsp_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
         send_random_batch(draw_batch_len());
      end
      rsp_max_gap = 10;
   endtask

   // receiver: per-beat random stall, plus a long hold on request
   always @(posedge clock) begin
      if (hold_request > 0) begin
         rsp_hold_left = hold_request;
         hold_request  = 0;
      end
      if (rsp_valid && !rsp_stall)
         rsp_stall_left = $urandom_range(0, rsp_max_gap);
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_rsp
      sorted_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sorted.size() == 0) begin
            $error("unexpected result beat: sorted_value %0d", rsp_sorted_value);
            mismatch_count++;
         end else begin
            want = pending_sorted.pop_front();
            if (rsp_sorted_value !== want.sorted_value) begin
               $error("sorted_value: expected %0d, actual %0d",
                      want.sorted_value, rsp_sorted_value);
               mismatch_count++;
            end
            if (rsp_final_result !== want.final_result) begin
               $error("final_result: expected %0b, actual %0b",
                      want.final_result, rsp_final_result);
               mismatch_count++;
            end
            if (rsp_overflowed !== want.overflowed) begin
               $error("overflowed: expected %0b, actual %0b",
                      want.overflowed, rsp_overflowed);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_duplicates();
      test_overflow();
      test_backpressure();
      test_random();
      wait_for_results();
      repeat (2 * DEPTH) @(posedge clock);
      if (mismatch_count == 0 && pending_sorted.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
